>>> rtl/rleb_pkg.sv
package rleb_pkg;

    // Fixed field widths
    localparam int unsigned CANVAS_REG_W = 12;
    localparam int unsigned COORD_W      = 13;
    localparam int unsigned POS_W        = 15;
    localparam int unsigned ADDR_W       = 22;
    localparam int unsigned CHAR_W       = 7;
    localparam int unsigned COUNT_W      = 7;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_FONT_ASCENDER = 2'd2,
        CFG_RLE_ENABLED   = 2'd3
    } cfg_reg_t;

    // Run header classes
    localparam logic [1:0] CLASS_LITERAL = 2'd0;
    localparam logic [1:0] CLASS_INK     = 2'd3;

    localparam logic [7:0] GREY_INK   = 8'hff;
    localparam logic [7:0] GREY_BLANK = 8'h00;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2e;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2b;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h58;

    // Step commands and operands for the pixel unit
    typedef struct packed {
        logic                      calc;
        logic                      mul;
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [7:0]                col;
        logic [7:0]                row;
    } pix_req_t;

    // Pixel handed to the output register
    typedef struct packed {
        logic              load;
        logic [CHAR_W-1:0] pchar;
        logic              last;
        logic              done;
    } emit_t;

    // Quantize a grey level in quarters
    function automatic logic [CHAR_W-1:0] quantize(input logic [7:0] grey);
        logic [CHAR_W-1:0] c;
        case (grey[7:6])
            2'd0:    c = CHAR_SPACE;
            2'd1:    c = CHAR_DOT;
            2'd2:    c = CHAR_PLUS;
            default: c = CHAR_X;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/rleb_pix.sv
module rleb_pix #(
    parameter int unsigned MAX_CANVAS_DIM = 2048
) (
    input  logic                                aclk,
    input  rleb_pkg::pix_req_t                  req,
    input  logic [rleb_pkg::CANVAS_REG_W-1:0]   canvas_width,
    input  logic [rleb_pkg::CANVAS_REG_W-1:0]   canvas_height,
    output logic [rleb_pkg::ADDR_W-1:0]         pixel_address,
    output logic                                visible
);

    localparam int unsigned DIM_W  = $clog2(MAX_CANVAS_DIM + 1);
    localparam int unsigned PROD_W = 2 * DIM_W;
    localparam int unsigned SUM_W  = PROD_W + 1;
    localparam int unsigned FULL_W = rleb_pkg::COORD_W;
    localparam int unsigned POS_W  = rleb_pkg::POS_W;
    localparam logic [FULL_W-1:0] MAX_DIM = FULL_W'(MAX_CANVAS_DIM);

    logic [FULL_W-1:0] w_full, h_full;
    logic [DIM_W-1:0]  w_lim;
    logic [POS_W-1:0]  px_next, py_next;
    logic [POS_W-1:0]  px_reg, py_reg;
    logic              vis_next, vis_reg, vism_reg;
    logic [PROD_W-1:0] prod_next, prod_reg;
    logic [DIM_W-1:0]  pxm_reg;
    logic [SUM_W-1:0]  sum;

    // Clamp canvas size to the supported dimension
    assign w_full = ({1'b0, canvas_width} < MAX_DIM) ? {1'b0, canvas_width} : MAX_DIM;
    assign h_full = ({1'b0, canvas_height} < MAX_DIM) ? {1'b0, canvas_height} : MAX_DIM;
    assign w_lim  = DIM_W'(w_full);

    assign px_next = POS_W'(req.origin_x) + POS_W'(req.col);
    assign py_next = POS_W'(req.origin_y) + POS_W'(req.row);

    assign vis_next = !px_reg[POS_W-1] && (px_reg[POS_W-2:0] < (POS_W-1)'(w_full))
                   && !py_reg[POS_W-1] && (py_reg[POS_W-2:0] < (POS_W-1)'(h_full));

    assign prod_next = PROD_W'(py_reg[DIM_W-1:0]) * PROD_W'(w_lim);

    always_ff @(posedge aclk) begin
        if (req.calc) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (req.mul) begin
            vis_reg  <= vis_next;
            vism_reg <= vis_next;
            prod_reg <= prod_next;
            pxm_reg  <= px_reg[DIM_W-1:0];
        end
    end

    assign sum           = SUM_W'(prod_reg) + SUM_W'(pxm_reg);
    assign pixel_address = vism_reg ? rleb_pkg::ADDR_W'(sum) : '0;
    assign visible       = vis_reg;

endmodule

>>> rtl/rleb_ctrl.sv
module rleb_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             mode,
    input  logic signed [11:0]               pen_x,
    input  logic signed [11:0]               pen_y,
    input  logic signed [7:0]                offset_left,
    input  logic signed [7:0]                offset_top,
    input  logic [7:0]                       glyph_height,
    input  logic [7:0]                       glyph_width,
    input  logic [7:0]                       data_byte,
    input  logic signed [7:0]                font_ascender,
    input  logic                             rle_enabled,
    input  logic                             out_free,
    output rleb_pkg::pix_req_t               pix_req,
    output rleb_pkg::emit_t                  emit
);

    localparam int unsigned CW = rleb_pkg::COORD_W;
    localparam int unsigned NW = rleb_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CALC = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic signed [CW-1:0]          origin_x_reg, origin_x_next;
    logic signed [CW-1:0]          origin_y_reg, origin_y_next;
    logic [7:0]                    rows_total_reg, rows_total_next;
    logic [7:0]                    cols_total_reg, cols_total_next;
    logic [7:0]                    row_index_reg, row_index_next;
    logic [7:0]                    col_index_reg, col_index_next;
    logic [NW-1:0]                 run_remaining_reg, run_remaining_next;
    logic [NW-1:0]                 count_reg, count_next;
    logic [rleb_pkg::CHAR_W-1:0]   char_reg, char_next;

    logic       complete;
    logic [8:0] col_inc;
    logic       wrap;
    logic [7:0] col_adv, row_adv;
    logic       adv_done, last;
    logic [NW-1:0] hdr_count;
    logic [7:0]    run_grey;

    assign complete = (cols_total_reg == 8'd0) || (row_index_reg >= rows_total_reg);

    // Raster advance of the pen inside the glyph
    assign col_inc  = {1'b0, col_index_reg} + 9'd1;
    assign wrap     = col_inc >= {1'b0, cols_total_reg};
    assign col_adv  = wrap ? 8'd0 : col_inc[7:0];
    assign row_adv  = wrap ? row_index_reg + 8'd1 : row_index_reg;
    assign adv_done = row_adv >= rows_total_reg;
    assign last     = (count_reg == NW'(1)) || adv_done;

    assign hdr_count = NW'(data_byte[5:0]) + NW'(1);
    assign run_grey  = (data_byte[7:6] == rleb_pkg::CLASS_INK) ? rleb_pkg::GREY_INK
                                                               : rleb_pkg::GREY_BLANK;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next         = state_reg;
        origin_x_next      = origin_x_reg;
        origin_y_next      = origin_y_reg;
        rows_total_next    = rows_total_reg;
        cols_total_next    = cols_total_reg;
        row_index_next     = row_index_reg;
        col_index_next     = col_index_reg;
        run_remaining_next = run_remaining_reg;
        count_next         = count_reg;
        char_next          = char_reg;
        emit               = '0;
        emit.pchar         = char_reg;
        emit.last          = last;
        emit.done          = adv_done;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (!mode) begin
                        origin_x_next      = CW'(pen_x) + CW'(offset_left);
                        origin_y_next      = CW'(pen_y) + CW'(font_ascender) - CW'(offset_top);
                        rows_total_next    = glyph_height;
                        cols_total_next    = glyph_width;
                        row_index_next     = '0;
                        col_index_next     = '0;
                        run_remaining_next = '0;
                    end else if (!complete) begin
                        if (!rle_enabled) begin
                            char_next  = rleb_pkg::quantize(data_byte);
                            count_next = NW'(1);
                            state_next = ST_CALC;
                        end else if (run_remaining_reg != '0) begin
                            char_next          = rleb_pkg::quantize(data_byte);
                            count_next         = NW'(1);
                            run_remaining_next = run_remaining_reg - NW'(1);
                            state_next         = ST_CALC;
                        end else if (data_byte[7:6] == rleb_pkg::CLASS_LITERAL) begin
                            run_remaining_next = hdr_count;
                        end else begin
                            char_next  = rleb_pkg::quantize(run_grey);
                            count_next = hdr_count;
                            state_next = ST_CALC;
                        end
                    end
                end
            end
            ST_CALC: state_next = ST_MUL;
            ST_MUL:  state_next = ST_EMIT;
            ST_EMIT: begin
                if (out_free) begin
                    emit.load      = 1'b1;
                    col_index_next = col_adv;
                    row_index_next = row_adv;
                    count_next     = count_reg - NW'(1);
                    // Drop any pending literal count once the glyph is finished
                    if (adv_done) begin
                        run_remaining_next = '0;
                    end
                    state_next = last ? ST_IDLE : ST_CALC;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            rows_total_reg    <= '0;
            cols_total_reg    <= '0;
            row_index_reg     <= '0;
            col_index_reg     <= '0;
            run_remaining_reg <= '0;
            count_reg         <= '0;
        end else begin
            state_reg         <= state_next;
            origin_x_reg      <= origin_x_next;
            origin_y_reg      <= origin_y_next;
            rows_total_reg    <= rows_total_next;
            cols_total_reg    <= cols_total_next;
            row_index_reg     <= row_index_next;
            col_index_reg     <= col_index_next;
            run_remaining_reg <= run_remaining_next;
            count_reg         <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg <= char_next;
    end

    assign pix_req.calc     = (state_reg == ST_CALC);
    assign pix_req.mul      = (state_reg == ST_MUL);
    assign pix_req.origin_x = origin_x_reg;
    assign pix_req.origin_y = origin_y_reg;
    assign pix_req.col      = col_index_reg;
    assign pix_req.row      = row_index_reg;

endmodule

>>> rtl/rle_glyph_blitter_unit.sv
// Channel    | Direction | Handshake          | Payload
// -----------+-----------+--------------------+-----------------------------------------
// s_ (input) | in        | s_tvalid/s_tready  | s_tdata glyph start or bitmap byte, s_tuser mode
// m_ (pixel) | out       | m_tvalid/m_tready  | m_tdata address+char, m_tuser flags, m_tlast
// cfg_       | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// Sequence: a start item, a literal header or an ignored byte is taken in the idle state;
// each pixel passes the pixel unit's steps (coordinates, multiply, add); a raw or literal
// byte gives one pixel and a run header n pixels (up to 64), all loaded before the next item.
// Reset: synchronous on aresetn low; registers return to 320 x 240, ascender 0, raw mode.
// Stalls: a low m_tready holds the pixel unit in its add step; the output register
// lets the next request in while the last pixel waits.
module rle_glyph_blitter_unit #(
    parameter int unsigned MAX_CANVAS_DIM = 2048
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // [11:0] pen_x, [23:12] pen_y, [31:24] offset_left, [39:32] offset_top,
    // [47:40] glyph_height, [55:48] glyph_width, [63:56] data_byte
    input  logic [63:0] s_tdata,
    // [0] mode
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // [21:0] pixel_address, [28:22] pixel_char, [31:29] zero
    output logic [31:0] m_tdata,
    // [0] visible, [1] glyph_done
    output logic [1:0]  m_tuser,
    // run_last
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int unsigned AW = rleb_pkg::ADDR_W;
    localparam int unsigned CH = rleb_pkg::CHAR_W;

    // Configuration registers
    logic [11:0]        canvas_width_reg;
    logic [11:0]        canvas_height_reg;
    logic signed [7:0]  font_ascender_reg;
    logic               rle_enabled_reg;

    // Output register
    logic               m_valid_reg;
    logic [AW-1:0]      m_addr_reg;
    logic [CH-1:0]      m_char_reg;
    logic               m_vis_reg;
    logic               m_last_reg;
    logic               m_done_reg;

    logic               out_free;
    rleb_pkg::pix_req_t pix_req;
    rleb_pkg::emit_t    emit;
    logic [AW-1:0]      pix_addr;
    logic               pix_vis;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            canvas_width_reg  <= 12'd320;
            canvas_height_reg <= 12'd240;
            font_ascender_reg <= '0;
            rle_enabled_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (rleb_pkg::cfg_reg_t'(cfg_index))
                rleb_pkg::CFG_CANVAS_WIDTH:  canvas_width_reg  <= cfg_data;
                rleb_pkg::CFG_CANVAS_HEIGHT: canvas_height_reg <= cfg_data;
                rleb_pkg::CFG_FONT_ASCENDER: font_ascender_reg <= cfg_data[7:0];
                rleb_pkg::CFG_RLE_ENABLED:   rle_enabled_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: decodes requests, tracks the raster position and run state
    rleb_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .mode          (s_tuser),
        .pen_x         (s_tdata[11:0]),
        .pen_y         (s_tdata[23:12]),
        .offset_left   (s_tdata[31:24]),
        .offset_top    (s_tdata[39:32]),
        .glyph_height  (s_tdata[47:40]),
        .glyph_width   (s_tdata[55:48]),
        .data_byte     (s_tdata[63:56]),
        .font_ascender (font_ascender_reg),
        .rle_enabled   (rle_enabled_reg),
        .out_free      (out_free),
        .pix_req       (pix_req),
        .emit          (emit)
    );

    // Shared pixel unit: clipping and row-major address, one pixel at a time
    rleb_pix #(
        .MAX_CANVAS_DIM (MAX_CANVAS_DIM)
    ) u_pix (
        .aclk          (aclk),
        .req           (pix_req),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .pixel_address (pix_addr),
        .visible       (pix_vis)
    );

    // Load a new pixel once the previous one has left or is leaving
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.load) begin
            m_addr_reg <= pix_addr;
            m_char_reg <= emit.pchar;
            m_vis_reg  <= pix_vis;
            m_last_reg <= emit.last;
            m_done_reg <= emit.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_char_reg, m_addr_reg};
    assign m_tuser  = {m_done_reg, m_vis_reg};
    assign m_tlast  = m_last_reg;

endmodule
